// File: rtl/eeas_pkg.sv
// ----------------------------------------------------------------------------
// eeas_pkg: shared types and codes of the EEPROM access sequencer
// Bus command codes, expected status codes, sequencer state and result types.
// ----------------------------------------------------------------------------
package eeas_pkg;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_SEND      = 3'd2,
        CMD_RECV_ACK  = 3'd3,
        CMD_RECV_NACK = 3'd4,
        CMD_STOP      = 3'd5
    } bus_cmd_t;

    localparam logic EV_REQUEST = 1'b0;
    localparam logic EV_BUS_DONE = 1'b1;

    localparam logic [7:0] DEV_ADDR_RESET = 8'hA0;
    localparam logic [7:0] STATUS_MASK    = 8'hF8;

    // masked bus status codes
    localparam logic [7:0] ST_START_SENT = 8'h08;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NACK    = 8'h58;

    typedef struct packed {
        logic        busy;
        logic [1:0]  op;
        logic [3:0]  step;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [15:0] acc;
    } seq_state_t;

    typedef struct packed {
        bus_cmd_t    cmd;
        logic [7:0]  bus_byte;
        logic        done;
        logic        success;
        logic [7:0]  failed_status;
        logic [15:0] read_data;
        logic        last;
    } res_t;

endpackage

// File: rtl/i2c_eeprom_access_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_access_sequencer_core: I2C EEPROM random read/write sequencer
// Steps a byte-level bus master through start, device address, 16-bit memory
// address and data or repeated-start receive, checking each bus status.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ----------------------------------
//  in        sink       in_valid / in_stall   event_kind, opcode, mem_address,
//                                             write_data, bus_status, bus_read_byte
//  out       source     out_valid / out_stall bus_command, bus_byte, done_res,
//                                             success, failed_status, read_data, last
//  cfg       sink       cfg_valid / cfg_ready cfg_data (device address byte)
//
// An event is taken into the input register, evaluated from it while the
// queue has room for two results, and its zero, one or two results are
// written into a four-entry result queue, from whose registers they are
// presented. One event per cycle is sustained while the queue drains;
// in_stall rises only when the event held in the input register finds
// fewer than two free queue entries. Reset clears the sequencer to idle,
// empties the queue and loads device address 0xA0.
// cfg_ready is always high.
//
module i2c_eeprom_access_sequencer_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        event_kind,
    input  logic [1:0]  opcode,
    input  logic [15:0] mem_address,
    input  logic [15:0] write_data,
    input  logic [7:0]  bus_status,
    input  logic [7:0]  bus_read_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  bus_command,
    output logic [7:0]  bus_byte,
    output logic        done_res,
    output logic        success,
    output logic [7:0]  failed_status,
    output logic [15:0] read_data,
    output logic        last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    // input register
    logic        in_vld_reg;
    logic        in_vld_next;
    logic        kind_reg;
    logic [1:0]  opcode_reg;
    logic [15:0] addr_reg;
    logic [15:0] wdata_reg;
    logic [7:0]  status_reg;
    logic [7:0]  rx_reg;

    logic [7:0]  dev_addr_reg;

    eeas_pkg::seq_state_t state_reg;
    eeas_pkg::seq_state_t state_eval;

    eeas_pkg::res_t res_first;
    eeas_pkg::res_t res_second;
    eeas_pkg::res_t head;
    logic [1:0]     res_count;
    logic [1:0]     push_count;
    logic           room_two;
    logic           process;
    logic           in_take;
    logic           pop;

    assign cfg_ready  = 1'b1;
    assign process    = in_vld_reg && room_two;
    assign in_stall   = in_vld_reg && !room_two;
    assign in_take    = in_valid && !in_stall;
    assign push_count = process ? res_count : 2'd0;
    assign pop        = out_valid && !out_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (process)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= event_kind;
            opcode_reg <= opcode;
            addr_reg   <= mem_address;
            wdata_reg  <= write_data;
            status_reg <= bus_status;
            rx_reg     <= bus_read_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            dev_addr_reg <= eeas_pkg::DEV_ADDR_RESET;
            state_reg    <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_valid && cfg_ready)
                dev_addr_reg <= cfg_data;
            if (process)
                state_reg <= state_eval;
        end
    end

    eeas_step u_step
    (
        .state         (state_reg),
        .dev_addr      (dev_addr_reg),
        .event_kind    (kind_reg),
        .opcode        (opcode_reg),
        .mem_address   (addr_reg),
        .write_data    (wdata_reg),
        .bus_status    (status_reg),
        .bus_read_byte (rx_reg),
        .state_next    (state_eval),
        .res_first     (res_first),
        .res_second    (res_second),
        .res_count     (res_count)
    );

    eeas_res_fifo u_res_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (res_first),
        .push_second (res_second),
        .pop         (pop),
        .head        (head),
        .not_empty   (out_valid),
        .room_two    (room_two)
    );

    assign bus_command   = head.cmd;
    assign bus_byte      = head.bus_byte;
    assign done_res      = head.done;
    assign success       = head.success;
    assign failed_status = head.failed_status;
    assign read_data     = head.read_data;
    assign last          = head.last;

endmodule

// File: rtl/eeas_step.sv
// ----------------------------------------------------------------------------
// eeas_step: next-state and result logic of the sequencer
// Checks one event against the current step and builds up to two results.
// ----------------------------------------------------------------------------
module eeas_step
(
    input  eeas_pkg::seq_state_t state,
    input  logic [7:0]           dev_addr,
    input  logic                 event_kind,
    input  logic [1:0]           opcode,
    input  logic [15:0]          mem_address,
    input  logic [15:0]          write_data,
    input  logic [7:0]           bus_status,
    input  logic [7:0]           bus_read_byte,
    output eeas_pkg::seq_state_t state_next,
    output eeas_pkg::res_t       res_first,
    output eeas_pkg::res_t       res_second,
    output logic [1:0]           res_count
);

    localparam logic [3:0] STEP_START   = 4'd0;
    localparam logic [3:0] STEP_DEV     = 4'd1;
    localparam logic [3:0] STEP_ADDR_HI = 4'd2;
    localparam logic [3:0] STEP_ADDR_LO = 4'd3;
    localparam logic [3:0] STEP_FOUR    = 4'd4;  // data byte / repeated start
    localparam logic [3:0] STEP_FIVE    = 4'd5;  // data low / read address
    localparam logic [3:0] STEP_RX_1    = 4'd6;
    localparam logic [3:0] STEP_RX_2    = 4'd7;

    function automatic logic [3:0] final_step(input logic [1:0] op);
        logic [3:0] fs;
        if (op[0])
            fs = op[1] ? STEP_RX_2 : STEP_RX_1;
        else
            fs = op[1] ? STEP_FIVE : STEP_FOUR;
        return fs;
    endfunction

    function automatic logic [7:0] expected_status(input logic [1:0] op,
                                                   input logic [3:0] s);
        logic [7:0] st;
        unique case (s)
            STEP_START:   st = eeas_pkg::ST_START_SENT;
            STEP_DEV:     st = eeas_pkg::ST_SLAW_ACK;
            STEP_ADDR_HI,
            STEP_ADDR_LO: st = eeas_pkg::ST_DATA_ACK;
            default:
            begin
                if (!op[0])
                    st = eeas_pkg::ST_DATA_ACK;
                else if (s == STEP_FOUR)
                    st = eeas_pkg::ST_RESTART;
                else if (s == STEP_FIVE)
                    st = eeas_pkg::ST_SLAR_ACK;
                else if (s == STEP_RX_1 && op[1])
                    st = eeas_pkg::ST_RX_ACK;
                else
                    st = eeas_pkg::ST_RX_NACK;
            end
        endcase
        return st;
    endfunction

    logic [7:0] status;
    logic [3:0] step_inc;
    logic       is_read;
    logic       is_word;

    always_comb
    begin
        state_next = state;
        res_first  = '0;
        res_second = '0;
        res_count  = 2'd0;
        status     = bus_status & eeas_pkg::STATUS_MASK;
        step_inc   = state.step + 4'd1;
        is_read    = state.op[0];
        is_word    = state.op[1];

        if (event_kind == eeas_pkg::EV_REQUEST)
        begin
            if (!state.busy)
            begin
                state_next.busy  = 1'b1;
                state_next.op    = opcode;
                state_next.addr  = mem_address;
                state_next.wdata = write_data;
                state_next.acc   = 16'h0000;
                state_next.step  = STEP_START;
                res_first.cmd    = eeas_pkg::CMD_START;
                res_first.last   = 1'b1;
                res_count        = 2'd1;
            end
        end
        else if (state.busy)
        begin
            if (status != expected_status(state.op, state.step))
            begin
                // abort without stop, report the offending status
                state_next.busy         = 1'b0;
                res_first.cmd           = eeas_pkg::CMD_NONE;
                res_first.done          = 1'b1;
                res_first.failed_status = status;
                res_first.last          = 1'b1;
                res_count               = 2'd1;
            end
            else
            begin
                if (is_read)
                begin
                    if (state.step == STEP_RX_1)
                        state_next.acc = is_word ? {bus_read_byte, 8'h00}
                                                 : {8'h00, bus_read_byte};
                    else if (state.step == STEP_RX_2)
                        state_next.acc = state.acc | {8'h00, bus_read_byte};
                end

                if (state.step >= final_step(state.op))
                begin
                    state_next.busy      = 1'b0;
                    res_first.cmd        = eeas_pkg::CMD_STOP;
                    res_second.cmd       = eeas_pkg::CMD_NONE;
                    res_second.done      = 1'b1;
                    res_second.success   = 1'b1;
                    res_second.read_data = is_read ? state_next.acc : 16'h0000;
                    res_second.last      = 1'b1;
                    res_count            = 2'd2;
                end
                else
                begin
                    state_next.step = step_inc;
                    res_first.last  = 1'b1;
                    res_count       = 2'd1;
                    unique case (step_inc)
                        STEP_START:
                            res_first.cmd = eeas_pkg::CMD_START;
                        STEP_DEV:
                        begin
                            res_first.cmd      = eeas_pkg::CMD_SEND;
                            res_first.bus_byte = dev_addr;
                        end
                        STEP_ADDR_HI:
                        begin
                            res_first.cmd      = eeas_pkg::CMD_SEND;
                            res_first.bus_byte = state.addr[15:8];
                        end
                        STEP_ADDR_LO:
                        begin
                            res_first.cmd      = eeas_pkg::CMD_SEND;
                            res_first.bus_byte = state.addr[7:0];
                        end
                        default:
                        begin
                            if (!is_read)
                            begin
                                res_first.cmd      = eeas_pkg::CMD_SEND;
                                res_first.bus_byte = (step_inc == STEP_FOUR && is_word)
                                                     ? state.wdata[15:8]
                                                     : state.wdata[7:0];
                            end
                            else if (step_inc == STEP_FOUR)
                                res_first.cmd = eeas_pkg::CMD_START;
                            else if (step_inc == STEP_FIVE)
                            begin
                                res_first.cmd      = eeas_pkg::CMD_SEND;
                                res_first.bus_byte = dev_addr | 8'h01;
                            end
                            else if (step_inc == STEP_RX_1 && is_word)
                                res_first.cmd = eeas_pkg::CMD_RECV_ACK;
                            else
                                res_first.cmd = eeas_pkg::CMD_RECV_NACK;
                        end
                    endcase
                end
            end
        end
    end

endmodule

// File: rtl/eeas_res_fifo.sv
// ----------------------------------------------------------------------------
// eeas_res_fifo: four-entry result queue
// Takes zero, one or two results per cycle and hands out one per transaction.
// ----------------------------------------------------------------------------
module eeas_res_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     push_count,
    input  eeas_pkg::res_t push_first,
    input  eeas_pkg::res_t push_second,
    input  logic           pop,
    output eeas_pkg::res_t head,
    output logic           not_empty,
    output logic           room_two
);

    eeas_pkg::res_t mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != 3'd0);
    assign room_two  = (count_reg <= 3'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem[wr_ptr_reg] <= push_first;
        if (push_count == 2'd2)
            mem[wr_ptr_reg + 2'd1] <= push_second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
